@@ rtl/core/fslm_pkg.sv @@
package fslm_pkg;

    localparam int DEF_MAX_PATTERN = 32;
    localparam int DEF_LINE_BITS   = 32;
    localparam int DEF_COLUMN_BITS = 16;

    localparam int NUM_PAT_WORDS = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 6;
    localparam int CFG_INDEX_W   = 3;
    localparam int LEN_BITS      = 6;
    localparam int PATTERN_BITS  = NUM_PAT_WORDS * CFG_DATA_W;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD3  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

    localparam logic [LEN_BITS-1:0] LEN_RESET  = 6'd1;
    localparam logic [7:0]          NEWLINE_BYTE = 8'h0A;

    typedef struct packed {
        logic [PATTERN_BITS-1:0] pattern;
        logic [LEN_BITS-1:0]     length;
    } t_cfg;

endpackage

@@ rtl/core/fslm_cfg_regs.sv @@
module fslm_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fslm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [fslm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [fslm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output fslm_pkg::t_cfg                    o_cfg
);
    import fslm_pkg::*;

    logic [CFG_DATA_W-1:0]  r_pat [NUM_PAT_WORDS];
    logic [LEN_BITS-1:0]    r_len;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic                   wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_ADDR_W-1:3];
    assign wr_en     = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_PAT_WORDS; w++) begin
                r_pat[w] <= '0;
            end
            r_len <= LEN_RESET;
        end else if (wr_en) begin
            case (reg_index)
                REG_PATTERN_WORD0:  r_pat[0] <= pwdata;
                REG_PATTERN_WORD1:  r_pat[1] <= pwdata;
                REG_PATTERN_WORD2:  r_pat[2] <= pwdata;
                REG_PATTERN_WORD3:  r_pat[3] <= pwdata;
                REG_PATTERN_LENGTH: r_len    <= pwdata[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_PATTERN_WORD0:  prdata = r_pat[0];
            REG_PATTERN_WORD1:  prdata = r_pat[1];
            REG_PATTERN_WORD2:  prdata = r_pat[2];
            REG_PATTERN_WORD3:  prdata = r_pat[3];
            REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(r_len);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.pattern = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};
    assign o_cfg.length  = r_len;

endmodule

@@ rtl/core/fslm_match_core.sv @@
module fslm_match_core #(
    parameter int MAX_PATTERN = fslm_pkg::DEF_MAX_PATTERN,
    parameter int LINE_BITS   = fslm_pkg::DEF_LINE_BITS,
    parameter int COLUMN_BITS = fslm_pkg::DEF_COLUMN_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fslm_pkg::t_cfg         i_cfg,
    input  logic                   i_accept,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_end_of_stream,
    output logic                   o_res_valid,
    output logic [LINE_BITS-1:0]   o_res_line,
    output logic [COLUMN_BITS-1:0] o_res_column
);
    import fslm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LEN_W-1:0]       LEN_MAX  = LEN_W'(MAX_PATTERN);
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    logic [7:0]             r_window [MAX_PATTERN];
    logic [LEN_W-1:0]       r_fill;
    logic [LINE_BITS-1:0]   r_line;
    logic [COLUMN_BITS-1:0] r_column;
    logic                   r_reported;

    logic [7:0]             n_window [MAX_PATTERN];
    logic [LEN_W-1:0]       n_fill;
    logic [LINE_BITS-1:0]   n_line;
    logic [COLUMN_BITS-1:0] n_column;
    logic                   n_reported;

    logic [7:0]             pat_byte [MAX_PATTERN];
    logic [LEN_W-1:0]       alen;
    logic [LEN_W-1:0]       offset;
    logic [LEN_W-1:0]       shifted_fill;
    logic [MAX_PATTERN-1:0] pos_ok;
    logic                   is_newline;
    logic                   hit;
    logic                   report;
    logic [LINE_BITS-1:0]   line_inc;
    logic [COLUMN_BITS-1:0] len_m1;

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pat_byte[k] = i_cfg.pattern[k*8 +: 8];
        end
    end

    // clamp the length register into 1..MAX_PATTERN
    always_comb begin
        if (i_cfg.length == '0) begin
            alen = LEN_W'(1);
        end else if (i_cfg.length > LEN_BITS'(MAX_PATTERN)) begin
            alen = LEN_MAX;
        end else begin
            alen = LEN_W'(i_cfg.length);
        end
    end

    assign offset = LEN_MAX - alen;

    // window after shifting in the new byte, newest at the top
    always_comb begin
        for (int p = 0; p < MAX_PATTERN - 1; p++) begin
            n_window[p] = r_window[p+1];
        end
        n_window[MAX_PATTERN-1] = i_data_byte;
    end

    assign shifted_fill = (r_fill == LEN_MAX) ? r_fill : r_fill + LEN_W'(1);

    // positions below the offset are outside the pattern and always pass
    always_comb begin
        for (int p = 0; p < MAX_PATTERN; p++) begin
            if (LEN_W'(p) < offset) begin
                pos_ok[p] = 1'b1;
            end else begin
                pos_ok[p] = (n_window[p] == pat_byte[IDX_W'(LEN_W'(p) - offset)]);
            end
        end
    end

    assign is_newline = (i_data_byte == NEWLINE_BYTE);
    assign hit        = (shifted_fill >= alen) && (&pos_ok);
    assign report     = i_accept && !is_newline && hit && !r_reported;

    assign line_inc = (r_line == LINE_MAX) ? r_line : r_line + LINE_BITS'(1);
    assign len_m1   = COLUMN_BITS'(alen - LEN_W'(1));

    always_comb begin
        o_res_valid = report;
        o_res_line  = line_inc;
        if (r_column == COL_MAX) begin
            o_res_column = COL_MAX;
        end else if (r_column >= len_m1) begin
            o_res_column = r_column - len_m1;
        end else begin
            o_res_column = '0;
        end
    end

    always_comb begin
        n_fill     = r_fill;
        n_line     = r_line;
        n_column   = r_column;
        n_reported = r_reported;
        if (i_accept) begin
            if (is_newline) begin
                n_line     = line_inc;
                n_column   = '0;
                n_fill     = '0;
                n_reported = 1'b0;
            end else begin
                n_fill     = shifted_fill;
                n_column   = (r_column == COL_MAX) ? r_column : r_column + COLUMN_BITS'(1);
                n_reported = r_reported | report;
            end
            if (i_end_of_stream) begin
                n_fill     = '0;
                n_line     = '0;
                n_column   = '0;
                n_reported = 1'b0;
            end
        end
    end

    // window bytes beyond the fill count never decide a hit, so no reset needed
    always_ff @(posedge i_clk) begin
        if (i_accept && !is_newline) begin
            for (int p = 0; p < MAX_PATTERN; p++) begin
                r_window[p] <= n_window[p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_line     <= '0;
            r_column   <= '0;
            r_reported <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_line     <= n_line;
            r_column   <= n_column;
            r_reported <= n_reported;
        end
    end

endmodule

@@ rtl/core/fslm_out_buf.sv @@
module fslm_out_buf #(
    parameter int DATA_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_ready
);
    logic              r_out_valid;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] r_skid_data;

    logic              n_out_valid;
    logic              n_skid_valid;
    logic [DATA_W-1:0] n_out_data;
    logic [DATA_W-1:0] n_skid_data;
    logic              take;

    assign take    = r_out_valid & i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (take) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || take) begin
                n_out_data  = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid_data  = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

endmodule

@@ rtl/core/fixed_string_line_matcher.sv @@
// Fixed-string line matcher: text enters one byte per item and an item is taken every cycle
// while the two-entry output buffer has room, so the block sustains one byte per clock.
// Each byte is compared against the programmed pattern (1 to MAX_PATTERN bytes) in the
// same cycle it is taken, over a shift window with all positions compared in parallel; a
// match result goes to the output register, or first to the skid entry while the output is
// held. Only the first match on a line is reported, as its 1-based line number and the
// 0-based column where the match starts; both counters saturate. A newline never takes
// part in a match. tlast on an input byte clears the line, column and window state after
// that byte. Program the pattern words and the length only while no text is in flight.
module fixed_string_line_matcher #(
    parameter int MAX_PATTERN = fslm_pkg::DEF_MAX_PATTERN,
    parameter int LINE_BITS   = fslm_pkg::DEF_LINE_BITS,
    parameter int COLUMN_BITS = fslm_pkg::DEF_COLUMN_BITS,
    parameter int OUT_W       = ((LINE_BITS + COLUMN_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fslm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [fslm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [fslm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // data_byte
    input  logic                              s_axis_tlast,  // end_of_stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [OUT_W-1:0]                  m_axis_tdata   // line_number, match_column
);
    import fslm_pkg::*;

    t_cfg                   cfg;
    logic                   in_accept;
    logic                   res_valid;
    logic [LINE_BITS-1:0]   res_line;
    logic [COLUMN_BITS-1:0] res_column;
    logic [OUT_W-1:0]       res_data;

    fslm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_accept = s_axis_tvalid & s_axis_tready;

    fslm_match_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_match_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_accept        (in_accept),
        .i_data_byte     (s_axis_tdata),
        .i_end_of_stream (s_axis_tlast),
        .o_res_valid     (res_valid),
        .o_res_line      (res_line),
        .o_res_column    (res_column)
    );

    assign res_data = OUT_W'({res_column, res_line});

    fslm_out_buf #(
        .DATA_W (OUT_W)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res_data),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .i_ready (m_axis_tready)
    );

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import fslm_pkg::*;

    localparam int OUT_W       = 48;
    localparam int QUIET_LIMIT = 20000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [31:0] line;
        logic [15:0] col;
    } t_found;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         after_drain;
    } t_text_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // data_byte
    logic              s_axis_tlast = 1'b0; // end_of_stream
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // line_number, match_column

    fixed_string_line_matcher uut (.*);

    always #5 i_clk = ~i_clk;

    // matcher state as predicted
    logic [255:0] pat_bits = '0;
    logic [5:0]   pat_len = LEN_RESET;
    logic [7:0]   win_bytes [32];
    int           win_fill = 0;
    logic [31:0]  line_cnt = '0;
    logic [15:0]  col_cnt = '0;
    bit           line_hit = 1'b0;

    t_text_item   text_q [$];
    t_found       hits_due [$];
    int           bytes_queued = 0;
    int           bytes_taken = 0;
    int           fails = 0;
    int           quiet = 0;
    int           send_idle = 0;
    int           take_idle = 0;
    int           holds_asked = 0;
    int           holds_served = 0;
    bit           in_taken = 1'b0;
    int           gap_left = 0;
    int           stall_left = 0;

    initial foreach (win_bytes[i]) win_bytes[i] = 8'h00;

    function automatic bit match_scan(input logic [7:0] ch, input logic eos,
                                      output t_found f);
        int  len;
        int  here;
        bit  hit;
        bit  found;
        found = 1'b0;
        f = '0;
        if (ch == NEWLINE_BYTE) begin
            if (line_cnt != '1) line_cnt++;
            col_cnt = '0;
            win_fill = 0;
            line_hit = 1'b0;
        end else begin
            len = (pat_len == 0) ? 1 : (pat_len > 32) ? 32 : pat_len;
            here = col_cnt;
            for (int i = 0; i < 31; i++) win_bytes[i] = win_bytes[i+1];
            win_bytes[31] = ch;
            if (win_fill < 32) win_fill++;
            hit = (win_fill >= len);
            for (int i = 0; i < len; i++)
                if (win_bytes[32-len+i] != pat_bits[8*i +: 8]) hit = 1'b0;
            if (hit && !line_hit) begin
                f.line = (line_cnt == '1) ? line_cnt : line_cnt + 1;
                if (here == 16'hFFFF) f.col = 16'hFFFF;
                else if (here >= len - 1) f.col = 16'(here - (len - 1));
                else f.col = '0;
                line_hit = 1'b1;
                found = 1'b1;
            end
            if (col_cnt != 16'hFFFF) col_cnt++;
        end
        if (eos) begin
            foreach (win_bytes[i]) win_bytes[i] = 8'h00;
            win_fill = 0;
            line_cnt = '0;
            col_cnt = '0;
            line_hit = 1'b0;
        end
        return found;
    endfunction

    // input side
    always @(negedge i_clk) begin
        t_text_item it;
        logic       nv;
        logic       load;
        load = 1'b0;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            nv = 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            nv = 1'b0;
        end else if (send_idle != 0 && $urandom_range(1, 100) <= send_idle) begin
            gap_left = $urandom_range(0, 14);
            nv = 1'b0;
        end else if (text_q.size() != 0 &&
                     !(text_q[0].after_drain && hits_due.size() != 0)) begin
            it = text_q.pop_front();
            load = 1'b1;
            nv = 1'b1;
        end else begin
            nv = 1'b0;
        end
        s_axis_tvalid <= nv;
        if (load) begin
            s_axis_tdata <= it.ch;
            s_axis_tlast <= it.last;
        end
    end

    // output side
    always @(negedge i_clk) begin
        logic rdy;
        if (holds_served != holds_asked) begin
            holds_served++;
            stall_left = LONG_HOLD;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (take_idle != 0 && $urandom_range(1, 100) <= take_idle) begin
            stall_left = $urandom_range(0, 14);
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin
        t_found f;
        logic [31:0] got_line;
        logic [15:0] got_col;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_line = m_axis_tdata[31:0];
                got_col = m_axis_tdata[47:32];
                if (hits_due.size() == 0) begin
                    $error("unexpected match: line %0d column %0d", got_line, got_col);
                    fails++;
                end else begin
                    f = hits_due.pop_front();
                    if (got_line !== f.line) begin
                        $error("line_number: expected %0d, got %0d", f.line, got_line);
                        fails++;
                    end
                    if (got_col !== f.col) begin
                        $error("match_column: expected %0d, got %0d", f.col, got_col);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_taken++;
                if (match_scan(s_axis_tdata, s_axis_tlast, f)) hits_due.push_back(f);
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_PATTERN_LENGTH) pat_len = val[5:0];
        else pat_bits[64*idx +: 64] = val;
    endtask

    task automatic use_pattern(input logic [255:0] bits, input logic [5:0] len);
        reg_write(REG_PATTERN_WORD0, bits[63:0]);
        reg_write(REG_PATTERN_WORD1, bits[127:64]);
        reg_write(REG_PATTERN_WORD2, bits[191:128]);
        reg_write(REG_PATTERN_WORD3, bits[255:192]);
        reg_write(REG_PATTERN_LENGTH, {58'd0, len});
    endtask

    // unused pattern bytes get random content
    function automatic logic [255:0] bytes_of(input string s);
        logic [255:0] v;
        for (int k = 0; k < 8; k++) v[32*k +: 32] = $urandom;
        for (int i = 0; i < s.len(); i++) v[8*i +: 8] = s[i];
        return v;
    endfunction

    function automatic logic [7:0] pick_byte(input bit wide);
        if (wide) return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    task automatic put_byte(input logic [7:0] ch, input logic last, input bit after_drain);
        t_text_item it;
        it.ch = ch;
        it.last = last;
        it.after_drain = after_drain;
        text_q.push_back(it);
        bytes_queued++;
    endtask

    task automatic put_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], last_at_end && (i == s.len() - 1), 1'b0);
    endtask

    // wait for the block to go idle before touching registers
    task automatic settle();
        while (bytes_taken != bytes_queued || hits_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic random_phase(input int n_items);
        logic [255:0] bits;
        logic [5:0]   len;
        logic [7:0]   pb [32];
        int           eff;
        int           cut;
        int           bad;
        int           start;
        bit           wide;
        wide = ($urandom_range(0, 9) < 3);
        for (int j = 0; j < 32; j++) begin
            pb[j] = pick_byte(wide);
            bits[8*j +: 8] = pb[j];
        end
        case ($urandom_range(0, 9))
            0: len = 6'd1;
            1: len = 6'd32;
            2: len = 6'($urandom_range(0, 63));
            default: len = 6'($urandom_range(1, 8));
        endcase
        eff = (len == 0) ? 1 : (len > 32) ? 32 : len;
        use_pattern(bits, len);
        start = bytes_queued;
        while (bytes_queued - start < n_items) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4: begin
                    // whole pattern, sometimes cut short or with one byte spoiled
                    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, eff) : eff;
                    bad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cut - 1) : -1;
                    for (int j = 0; j < cut; j++)
                        put_byte((j == bad) ? pick_byte(1'b1) : pb[j], 1'b0, 1'b0);
                end
                5, 6: repeat ($urandom_range(1, 6)) put_byte(pick_byte(wide), 1'b0, 1'b0);
                7: repeat ($urandom_range(1, 4)) put_byte(pick_byte(1'b1), 1'b0, 1'b0);
                8, 9: put_byte(NEWLINE_BYTE, 1'b0, $urandom_range(0, 19) == 0);
                10: put_byte(pick_byte(wide), 1'b1, 1'b0);
                default: put_byte(NEWLINE_BYTE, 1'b1, 1'b0);
            endcase
        end
        settle();
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset pattern is a single zero byte
        send_idle = 10;
        take_idle = 10;
        put_byte(8'h00, 1'b0, 1'b0);
        put_byte(NEWLINE_BYTE, 1'b0, 1'b0);
        settle();

        use_pattern(bytes_of("ab"), 6'd2);
        put_text("xab\n", 1'b0);
        put_text("abab\n", 1'b0);
        put_byte(8'h00, 1'b0, 1'b0);
        put_byte(8'hFF, 1'b0, 1'b0);
        put_text("a\nb\n", 1'b0);
        put_text("ab", 1'b1);
        put_text("ab\n", 1'b0);
        settle();

        // zero length behaves as one
        use_pattern(bytes_of("q"), 6'd0);
        put_text("zq\n", 1'b0);
        settle();

        // a newline inside the pattern can never match
        use_pattern(bytes_of("a\nb"), 6'd3);
        put_text("a\nb\n", 1'b0);
        settle();

        // oversized length clamps to the full window
        use_pattern('1, 6'd63);
        repeat (32) put_byte(8'hFF, 1'b0, 1'b0);
        put_byte(NEWLINE_BYTE, 1'b0, 1'b0);
        settle();

        // match far into one long line
        send_idle = 2;
        take_idle = 5;
        use_pattern(bytes_of("Zz"), 6'd2);
        repeat (200) put_byte("y", 1'b0, 1'b0);
        put_text("Zz\n", 1'b1);
        settle();

        // back pressure: long output stall, then a pause until results drain
        send_idle = 0;
        take_idle = 0;
        use_pattern('0, 6'd1);
        holds_asked++;
        repeat (30) begin
            put_byte(8'h00, 1'b0, 1'b0);
            put_byte(NEWLINE_BYTE, 1'b0, 1'b0);
        end
        put_byte(8'h00, 1'b0, 1'b1);
        put_byte(NEWLINE_BYTE, 1'b1, 1'b0);
        settle();

        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 3))
                0: send_idle = 0;
                1: send_idle = 5;
                2: send_idle = 15;
                default: send_idle = 40;
            endcase
            case ($urandom_range(0, 3))
                0: take_idle = 0;
                1: take_idle = 5;
                2: take_idle = 15;
                default: take_idle = 40;
            endcase
            random_phase(125);
        end
        send_idle = 0;
        take_idle = 0;
        random_phase(110);

        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/fslm_pkg.sv
rtl/core/fslm_cfg_regs.sv
rtl/core/fslm_match_core.sv
rtl/core/fslm_out_buf.sv
rtl/core/fixed_string_line_matcher.sv
tb/sv/tb.sv
